@@ rtl/array_list_engine_defines.svh @@
// ----------------------------------------------------------------------------
// Array list engine assertion macros
// Property wrappers used by the array list engine top level.
// ----------------------------------------------------------------------------
`ifndef ARRAY_LIST_ENGINE_DEFINES_SVH
`define ARRAY_LIST_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, masked during reset
`define ALE_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, masked during reset
`define ALE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ALE_ASSERT(label, ante, cons, msg)
`define ALE_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

@@ rtl/ale_pkg.sv @@
// ----------------------------------------------------------------------------
// Array list engine package
// Word types, opcodes, status codes and cell commands shared by the engine, its interfaces and cells.
// ----------------------------------------------------------------------------
package ale_pkg;

    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_APPEND = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_INSERT = 3'd3;
    localparam logic [2:0] OP_DELETE = 3'd4;
    localparam logic [2:0] OP_SEARCH = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_BAD_POS   = 2'd3;

    // search reports at most this many matches per command word
    localparam int MAX_RESULTS = 64;
    localparam int RES_W       = $clog2(MAX_RESULTS);

    localparam logic [2:0] CELL_HOLD      = 3'd0;
    localparam logic [2:0] CELL_WRITE     = 3'd1;
    localparam logic [2:0] CELL_INSERT    = 3'd2;
    localparam logic [2:0] CELL_REMOVE    = 3'd3;
    localparam logic [2:0] CELL_LOAD_TAP  = 3'd4;
    localparam logic [2:0] CELL_SHIFT_TAP = 3'd5;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] item_value;
        logic [6:0]         position;
    } t_cmd_word;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [5:0]         found_position;
        logic [6:0]         removed_count;
        logic               last;
    } t_res_word;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] value;
    } t_cell_cmd;

endpackage

@@ rtl/ale_if.sv @@
// ----------------------------------------------------------------------------
// Array list engine stream interfaces
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface ale_cmd_if ();
    logic              valid;
    logic              ready;
    ale_pkg::t_cmd_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ale_res_if ();
    logic              valid;
    logic              ready;
    ale_pkg::t_res_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/array_list_engine.sv @@
// ----------------------------------------------------------------------------
// Array list engine
// Bounded ordered list of signed 32-bit values kept in a row of cells, with
// clear, append, read, insert, delete-all-matches and search commands.
// ----------------------------------------------------------------------------
//  channel   dir  port   words per command
//  command   in   i_cmd  one
//  result    out  o_res  one; search gives one per match (up to 64)
//
//  Clear, append and insert finish in the accept cycle (insert shifts list-wide).
//  Read loads the tap chain, then shifts it down until the value reaches cell 0.
//  Delete and search scan one cell per cycle; a delete hit compacts, index stays.
//  A stalled result port holds the scan; a new command is taken only when idle.
//  Reset clears the length and the controller; element contents are not reset.
// ----------------------------------------------------------------------------
`include "array_list_engine_defines.svh"

module array_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ale_cmd_if.sink  i_cmd,
    ale_res_if.source o_res
);

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = (LW > 7) ? LW : 7;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_DEL  = 2'd2;
    localparam logic [1:0] S_SRCH = 2'd3;

    logic [1:0]                   r_state, n_state;
    logic [LW-1:0]                r_len, n_len;
    logic [LW-1:0]                r_key, n_key;
    logic signed [31:0]           r_val, n_val;
    logic [LW-1:0]                r_removed, n_removed;
    logic [ale_pkg::RES_W-1:0]    r_cnt, n_cnt;
    logic                         r_out_valid;
    ale_pkg::t_res_word           r_res;

    ale_pkg::t_cell_cmd           w_cell_cmd;
    logic [LW-1:0]                w_cell_key;
    ale_pkg::t_res_word           w_res;
    logic                         w_emit;
    logic                         w_can_emit;
    logic                         w_accept;
    logic                         w_scan_end;
    logic                         w_hit;
    logic                         w_any_later;
    logic [CW-1:0]                w_pos_ext;
    logic [CW-1:0]                w_len_ext;

    logic signed [31:0]           w_data [CAPACITY];
    logic signed [31:0]           w_tap  [CAPACITY];
    logic [CAPACITY-1:0]          w_match;
    logic [CAPACITY-1:0]          w_later;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ale_cell #(
            .IDX (g),
            .LW  (LW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_cmd        (w_cell_cmd),
            .i_key        (w_cell_key),
            .i_len        (r_len),
            .i_lower_data (w_data[(g == 0) ? 0 : g - 1]),
            .i_upper_data (w_data[(g == CAPACITY - 1) ? g : g + 1]),
            .i_upper_tap  (w_tap[(g == CAPACITY - 1) ? g : g + 1]),
            .o_data       (w_data[g]),
            .o_tap        (w_tap[g]),
            .o_match      (w_match[g]),
            .o_later      (w_later[g])
        );
    end

    assign w_can_emit  = !r_out_valid || o_res.ready;
    assign i_cmd.ready = (r_state == S_IDLE) && w_can_emit;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_pos_ext   = CW'(i_cmd.data.position);
    assign w_len_ext   = CW'(r_len);
    assign w_scan_end  = (r_key >= r_len);
    assign w_hit       = w_match[r_key[IW-1:0]];
    assign w_any_later = |w_later;

    always_comb begin
        n_state          = r_state;
        n_len            = r_len;
        n_key            = r_key;
        n_val            = r_val;
        n_removed        = r_removed;
        n_cnt            = r_cnt;
        w_cell_cmd.op    = ale_pkg::CELL_HOLD;
        w_cell_cmd.value = r_val;
        w_cell_key       = r_key;
        w_emit           = 1'b0;
        w_res            = '0;
        w_res.status     = ale_pkg::ST_OK;
        w_res.last       = 1'b1;

        case (r_state)
            S_IDLE: begin
                w_cell_cmd.value = i_cmd.data.item_value;
                if (w_accept) begin
                    case (i_cmd.data.opcode)
                        ale_pkg::OP_CLEAR: begin
                            n_len  = '0;
                            w_emit = 1'b1;
                        end
                        ale_pkg::OP_APPEND: begin
                            w_emit = 1'b1;
                            if (r_len >= LW'(CAPACITY)) begin
                                w_res.status = ale_pkg::ST_FULL;
                            end else begin
                                w_cell_cmd.op = ale_pkg::CELL_WRITE;
                                w_cell_key    = r_len;
                                n_len         = r_len + 1'b1;
                            end
                        end
                        ale_pkg::OP_READ: begin
                            if (w_pos_ext >= w_len_ext) begin
                                w_emit       = 1'b1;
                                w_res.status = ale_pkg::ST_BAD_POS;
                            end else begin
                                w_cell_cmd.op = ale_pkg::CELL_LOAD_TAP;
                                n_key         = LW'(i_cmd.data.position);
                                n_state       = S_READ;
                            end
                        end
                        ale_pkg::OP_INSERT: begin
                            w_emit = 1'b1;
                            if (r_len >= LW'(CAPACITY)) begin
                                w_res.status = ale_pkg::ST_FULL;
                            end else if (w_pos_ext > w_len_ext) begin
                                w_res.status = ale_pkg::ST_BAD_POS;
                            end else begin
                                w_cell_cmd.op = ale_pkg::CELL_INSERT;
                                w_cell_key    = LW'(i_cmd.data.position);
                                n_len         = r_len + 1'b1;
                            end
                        end
                        ale_pkg::OP_DELETE: begin
                            n_val     = i_cmd.data.item_value;
                            n_key     = '0;
                            n_removed = '0;
                            n_state   = S_DEL;
                        end
                        ale_pkg::OP_SEARCH: begin
                            n_val   = i_cmd.data.item_value;
                            n_key   = '0;
                            n_cnt   = '0;
                            n_state = S_SRCH;
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                if (r_key == '0) begin
                    if (w_can_emit) begin
                        w_emit           = 1'b1;
                        w_res.read_value = w_tap[0];
                        n_state          = S_IDLE;
                    end
                end else begin
                    w_cell_cmd.op = ale_pkg::CELL_SHIFT_TAP;
                    n_key         = r_key - 1'b1;
                end
            end
            S_DEL: begin
                if (w_scan_end) begin
                    if (w_can_emit) begin
                        w_emit              = 1'b1;
                        w_res.status        = (r_removed != '0) ? ale_pkg::ST_OK
                                                                : ale_pkg::ST_NOT_FOUND;
                        w_res.removed_count = 7'(r_removed);
                        n_state             = S_IDLE;
                    end
                end else if (w_hit) begin
                    // compact: cells at and above the key pull down, key stays
                    w_cell_cmd.op = ale_pkg::CELL_REMOVE;
                    n_len         = r_len - 1'b1;
                    n_removed     = r_removed + 1'b1;
                end else begin
                    n_key = r_key + 1'b1;
                end
            end
            S_SRCH: begin
                if (w_scan_end) begin
                    if (w_can_emit) begin
                        w_emit       = 1'b1;
                        w_res.status = ale_pkg::ST_NOT_FOUND;
                        n_state      = S_IDLE;
                    end
                end else if (w_hit) begin
                    if (w_can_emit) begin
                        w_emit               = 1'b1;
                        w_res.found_position = 6'(r_key);
                        w_res.last           = !w_any_later ||
                            (r_cnt == ale_pkg::RES_W'(ale_pkg::MAX_RESULTS - 1));
                        n_key                = r_key + 1'b1;
                        n_cnt                = r_cnt + 1'b1;
                        if (w_res.last) n_state = S_IDLE;
                    end
                end else begin
                    n_key = r_key + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_val     <= n_val;
        r_removed <= n_removed;
        r_cnt     <= n_cnt;
        if (w_emit) r_res <= w_res;
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_res;

    `ALE_ASSERT(a_len_bound, 1'b1, r_len <= LW'(CAPACITY), "list length above capacity")
    `ALE_ASSERT(a_read_key, r_state == S_READ, r_key < r_len, "read index past length")
    `ALE_ASSERT_NXT(a_del_shrink, r_state == S_DEL, r_len <= $past(r_len), "delete grew list")
    `ALE_ASSERT(a_emit_slot, w_emit, w_can_emit, "result written over a waiting word")

endmodule

@@ rtl/ale_cell.sv @@
// ----------------------------------------------------------------------------
// Array list cell
// Holds one list element, shifts it to or from its neighbors on insert and
// remove, compares it with the broadcast value and carries a read tap.
// ----------------------------------------------------------------------------
module ale_cell #(
    parameter int IDX = 0,
    parameter int LW  = 7
) (
    input  logic               i_clk,
    input  ale_pkg::t_cell_cmd i_cmd,
    input  logic [LW-1:0]      i_key,
    input  logic [LW-1:0]      i_len,
    input  logic signed [31:0] i_lower_data,
    input  logic signed [31:0] i_upper_data,
    input  logic signed [31:0] i_upper_tap,
    output logic signed [31:0] o_data,
    output logic signed [31:0] o_tap,
    output logic               o_match,
    output logic               o_later
);

    localparam logic [LW-1:0] C_IDX = LW'(IDX);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;
    logic signed [31:0] r_tap;
    logic signed [31:0] n_tap;

    always_comb begin
        n_data = r_data;
        n_tap  = r_tap;
        case (i_cmd.op)
            ale_pkg::CELL_WRITE: begin
                if (C_IDX == i_key) n_data = i_cmd.value;
            end
            ale_pkg::CELL_INSERT: begin
                if (C_IDX == i_key) begin
                    n_data = i_cmd.value;
                end else if (C_IDX > i_key && C_IDX <= i_len) begin
                    n_data = i_lower_data;
                end
            end
            ale_pkg::CELL_REMOVE: begin
                // pull the upper neighbor down over the removed entry
                if (C_IDX >= i_key) n_data = i_upper_data;
            end
            ale_pkg::CELL_LOAD_TAP:  n_tap = r_data;
            ale_pkg::CELL_SHIFT_TAP: n_tap = i_upper_tap;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_tap  <= n_tap;
    end

    assign o_data  = r_data;
    assign o_tap   = r_tap;
    assign o_match = (r_data == i_cmd.value) && (C_IDX < i_len);
    assign o_later = o_match && (C_IDX > i_key);

endmodule
